// ===== hw/rtl/iee_pkg.sv =====
// ----------------------------------------------------------------------------
// Infix expression evaluator package
// Shared types, character codes and constants of the expression evaluator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package iee_pkg;

   localparam int WORD_BITS_DEFAULT = 32;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [7:0] CHAR_PLUS  = 8'h2b;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] CHAR_STAR  = 8'h2a;
   localparam logic [7:0] CHAR_SLASH = 8'h2f;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_DIVZERO  = 2'd1;
   localparam logic [1:0] ERR_OVERFLOW = 2'd2;

   localparam int FLAG_DIVZERO  = 0;
   localparam int FLAG_OVERFLOW = 1;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_MUL = 2'd1,
      OP_DIV = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_DIGIT = 2'd1,
      KIND_OP    = 2'd2
   } kind_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic [1:0]         error_code;
   } rsp_type;

   typedef struct packed {
      kind_type   kind;
      logic [3:0] digit;
      op_type     op;
      logic       negate;
      logic       last;
   } token_type;

   typedef struct packed {
      logic start;
      logic is_div;
   } alu_req_type;

   typedef struct packed {
      logic done;
      logic overflow;
   } alu_rsp_type;

endpackage

`default_nettype wire

// ===== hw/rtl/iee_front.sv =====
// ----------------------------------------------------------------------------
// Expression evaluator front end
// Accepts characters, classifies them into tokens and drops ignored ones.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iee_front (
   input  wire                  req_push,
   input  iee_pkg::req_type     req_data,
   output logic                 req_full,
   output logic                 fifo_push,
   output iee_pkg::token_type   fifo_data,
   input  wire                  fifo_full
);
   import iee_pkg::*;

   token_type tok;

   always_comb begin
      tok        = '0;
      tok.kind   = KIND_NONE;
      tok.op     = OP_ADD;
      tok.last   = req_data.last_char;
      if (req_data.char_code >= CHAR_ZERO && req_data.char_code <= CHAR_NINE) begin
         tok.kind  = KIND_DIGIT;
         tok.digit = 4'(req_data.char_code - CHAR_ZERO);
      end else begin
         unique case (req_data.char_code)
            CHAR_PLUS: begin
               tok.kind = KIND_OP;
            end
            CHAR_MINUS: begin
               tok.kind   = KIND_OP;
               tok.negate = 1'b1;
            end
            CHAR_STAR: begin
               tok.kind = KIND_OP;
               tok.op   = OP_MUL;
            end
            CHAR_SLASH: begin
               tok.kind = KIND_OP;
               tok.op   = OP_DIV;
            end
            default: begin
               tok.kind = KIND_NONE;
            end
         endcase
      end
   end

   assign req_full  = fifo_full;
   assign fifo_data = tok;
   assign fifo_push = req_push && !fifo_full && (tok.kind != KIND_NONE || tok.last);

endmodule

`default_nettype wire

// ===== hw/rtl/iee_fifo.sv =====
// ----------------------------------------------------------------------------
// Expression evaluator token queue
// Short queue that decouples the classifier from the executing back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iee_fifo #(
   parameter int DEPTH = iee_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push,
   input  iee_pkg::token_type   push_data,
   output logic                 full,
   input  wire                  pop,
   output iee_pkg::token_type   pop_data,
   output logic                 empty
);
   import iee_pkg::*;

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   token_type            store_ff [DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic                 do_push, do_pop;

   assign full     = (count_ff == CNT_BITS'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/iee_alu.sv =====
// ----------------------------------------------------------------------------
// Expression evaluator multiply and divide unit
// Iterative signed multiplier and divider, one bit per cycle, with overflow.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iee_alu #(
   parameter int WORD_BITS = iee_pkg::WORD_BITS_DEFAULT
) (
   input  wire                    clock,
   input  wire                    reset,
   input  iee_pkg::alu_req_type   alu_req,
   input  wire  [WORD_BITS-1:0]   opnd_a,
   input  wire  [WORD_BITS-1:0]   opnd_b,
   output iee_pkg::alu_rsp_type   alu_rsp,
   output logic [WORD_BITS-1:0]   result
);
   import iee_pkg::*;

   localparam int W = WORD_BITS;
   localparam int CNT_BITS = $clog2(W + 1);
   localparam logic [W-1:0] WSIGN = W'(1) << (W - 1);
   localparam logic [W-1:0] WMAX  = WSIGN - W'(1);

   typedef enum logic [1:0] {
      A_IDLE,
      A_RUN,
      A_DONE
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [W-1:0]         opa_ff, opa_in;
   logic [W-1:0]         shf_ff, shf_in;
   logic [W-1:0]         rem_ff, rem_in;
   logic [2*W-1:0]       prod_ff, prod_in;
   logic                 is_div_ff, is_div_in;
   logic                 negr_ff, negr_in;

   logic [W-1:0]         mag_a, mag_b, mag_r;
   logic [W:0]           rem_shift;
   logic                 rem_ge;
   logic [2*W-1:0]       limit;

   assign mag_a     = opnd_a[W-1] ? W'(0) - opnd_a : opnd_a;
   assign mag_b     = opnd_b[W-1] ? W'(0) - opnd_b : opnd_b;
   assign rem_shift = {rem_ff, shf_ff[W-1]};
   assign rem_ge    = (rem_shift >= {1'b0, opa_ff});
   assign limit     = negr_ff ? {W'(0), WSIGN} : {W'(0), WMAX};
   assign mag_r     = is_div_ff ? shf_ff : prod_ff[W-1:0];
   assign result    = negr_ff ? W'(0) - mag_r : mag_r;

   always_comb begin
      alu_rsp.done     = (state_ff == A_DONE);
      alu_rsp.overflow = is_div_ff ? (!negr_ff && shf_ff[W-1]) : (prod_ff > limit);
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      opa_in    = opa_ff;
      shf_in    = shf_ff;
      rem_in    = rem_ff;
      prod_in   = prod_ff;
      is_div_in = is_div_ff;
      negr_in   = negr_ff;
      unique case (state_ff)
         A_IDLE: begin
            if (alu_req.start) begin
               state_in  = A_RUN;
               cnt_in    = CNT_BITS'(W);
               is_div_in = alu_req.is_div;
               negr_in   = opnd_a[W-1] ^ opnd_b[W-1];
               opa_in    = alu_req.is_div ? mag_b : mag_a;
               shf_in    = alu_req.is_div ? mag_a : mag_b;
               rem_in    = '0;
               prod_in   = '0;
            end
         end
         A_RUN: begin
            if (is_div_ff) begin
               rem_in = rem_ge ? W'(rem_shift - {1'b0, opa_ff}) : W'(rem_shift);
               shf_in = {shf_ff[W-2:0], rem_ge};
            end else begin
               prod_in = {prod_ff[2*W-2:0], 1'b0} + (shf_ff[W-1] ? {W'(0), opa_ff} : '0);
               shf_in  = {shf_ff[W-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CNT_BITS'(1)) begin
               state_in = A_DONE;
            end
         end
         A_DONE: begin
            state_in = A_IDLE;
         end
         default: begin
            state_in = A_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      opa_ff    <= opa_in;
      shf_ff    <= shf_in;
      rem_ff    <= rem_in;
      prod_ff   <= prod_in;
      is_div_ff <= is_div_in;
      negr_ff   <= negr_in;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/iee_back.sv =====
// ----------------------------------------------------------------------------
// Expression evaluator back end
// Executes tokens: builds numbers, applies operators and emits results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iee_back #(
   parameter int WORD_BITS = iee_pkg::WORD_BITS_DEFAULT
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    fifo_empty,
   input  iee_pkg::token_type     fifo_data,
   output logic                   fifo_pop,
   output iee_pkg::alu_req_type   alu_req,
   output logic [WORD_BITS-1:0]   opnd_a,
   output logic [WORD_BITS-1:0]   opnd_b,
   input  iee_pkg::alu_rsp_type   alu_rsp,
   input  wire  [WORD_BITS-1:0]   result,
   output logic                   rsp_empty,
   input  wire                    rsp_pop,
   output iee_pkg::rsp_type       rsp_data
);
   import iee_pkg::*;

   localparam int W = WORD_BITS;
   localparam logic [W-1:0] WSIGN = W'(1) << (W - 1);
   localparam logic [W-1:0] WMAX  = WSIGN - W'(1);

   typedef enum logic [1:0] {
      S_TAKE,
      S_APPLY,
      S_WAIT,
      S_FINISH
   } state_type;

   state_type     state_ff, state_in;
   logic [W-1:0]  sum_ff, sum_in;
   logic [W-1:0]  term_ff, term_in;
   logic [W-1:0]  acc_ff, acc_in;
   op_type        op_ff, op_in;
   logic          have_ff, have_in;
   logic          neg_ff, neg_in;
   logic [1:0]    err_ff, err_in;
   token_type     tok_ff, tok_in;
   logic          out_valid_ff, out_valid_in;
   rsp_type       out_ff, out_in;

   token_type     tok_sel;
   logic          tok_done;
   logic          have_now;
   logic [W+3:0]  acc_wide, acc_times10;
   logic [W-1:0]  number;
   logic [W-1:0]  sum_add;
   logic          add_ovf;
   logic [1:0]    err_fin;
   logic [1:0]    code_fin;

   assign tok_sel     = (state_ff == S_TAKE) ? fifo_data : tok_ff;
   assign acc_wide    = {4'b0, acc_ff};
   assign acc_times10 = (acc_wide << 3) + (acc_wide << 1) + (W+4)'(fifo_data.digit);
   assign number      = neg_ff ? W'(0) - acc_ff : acc_ff;
   assign sum_add     = sum_ff + term_ff;
   assign add_ovf     = (sum_ff[W-1] == term_ff[W-1]) && (sum_add[W-1] != sum_ff[W-1]);
   assign err_fin     = err_ff | (add_ovf ? 2'b10 : 2'b00);
   assign code_fin    = err_fin[FLAG_DIVZERO]  ? ERR_DIVZERO  :
                        err_fin[FLAG_OVERFLOW] ? ERR_OVERFLOW : ERR_NONE;
   assign opnd_a      = term_ff;
   assign opnd_b      = number;
   assign rsp_empty   = !out_valid_ff;
   assign rsp_data    = out_ff;

   always_comb begin
      state_in       = state_ff;
      sum_in         = sum_ff;
      term_in        = term_ff;
      acc_in         = acc_ff;
      op_in          = op_ff;
      have_in        = have_ff;
      neg_in         = neg_ff;
      err_in         = err_ff;
      tok_in         = tok_ff;
      out_valid_in   = out_valid_ff && !rsp_pop;
      out_in         = out_ff;
      fifo_pop       = 1'b0;
      alu_req.start  = 1'b0;
      alu_req.is_div = 1'b0;
      tok_done       = 1'b0;
      have_now       = have_ff;

      unique case (state_ff)
         S_TAKE: begin
            if (!fifo_empty) begin
               fifo_pop = 1'b1;
               tok_in   = fifo_data;
               if (fifo_data.kind == KIND_DIGIT) begin
                  if (acc_times10 > (W+4)'(WMAX)) begin
                     err_in[FLAG_OVERFLOW] = 1'b1;
                  end
                  acc_in   = acc_times10[W-1:0];
                  have_in  = 1'b1;
                  have_now = 1'b1;
               end
               if ((fifo_data.kind == KIND_OP || fifo_data.last) && have_now) begin
                  state_in = S_APPLY;
               end else begin
                  tok_done = 1'b1;
               end
            end
         end
         S_APPLY: begin
            if (neg_ff && acc_ff == WSIGN) begin
               err_in[FLAG_OVERFLOW] = 1'b1;
            end
            case (op_ff)
               OP_MUL: begin
                  alu_req.start = 1'b1;
                  state_in      = S_WAIT;
               end
               OP_DIV: begin
                  if (number == '0) begin
                     err_in[FLAG_DIVZERO] = 1'b1;
                     acc_in   = '0;
                     have_in  = 1'b0;
                     tok_done = 1'b1;
                  end else begin
                     alu_req.start  = 1'b1;
                     alu_req.is_div = 1'b1;
                     state_in       = S_WAIT;
                  end
               end
               default: begin
                  sum_in  = sum_add;
                  term_in = number;
                  if (add_ovf) begin
                     err_in[FLAG_OVERFLOW] = 1'b1;
                  end
                  acc_in   = '0;
                  have_in  = 1'b0;
                  tok_done = 1'b1;
               end
            endcase
         end
         S_WAIT: begin
            if (alu_rsp.done) begin
               term_in = result;
               if (alu_rsp.overflow) begin
                  err_in[FLAG_OVERFLOW] = 1'b1;
               end
               acc_in   = '0;
               have_in  = 1'b0;
               tok_done = 1'b1;
            end
         end
         S_FINISH: begin
            if (!out_valid_ff || rsp_pop) begin
               out_valid_in        = 1'b1;
               out_in.error_code   = code_fin;
               out_in.value        = (code_fin == ERR_NONE) ? 32'($signed(sum_add)) : '0;
               sum_in              = '0;
               term_in             = '0;
               acc_in              = '0;
               op_in               = OP_ADD;
               have_in             = 1'b0;
               neg_in              = 1'b0;
               err_in              = '0;
               state_in            = S_TAKE;
            end
         end
         default: begin
            state_in = S_TAKE;
         end
      endcase

      if (tok_done) begin
         if (tok_sel.kind == KIND_OP) begin
            neg_in = tok_sel.negate;
            op_in  = tok_sel.op;
         end
         state_in = tok_sel.last ? S_FINISH : S_TAKE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_TAKE;
         sum_ff       <= '0;
         term_ff      <= '0;
         acc_ff       <= '0;
         op_ff        <= OP_ADD;
         have_ff      <= 1'b0;
         neg_ff       <= 1'b0;
         err_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         term_ff      <= term_in;
         acc_ff       <= acc_in;
         op_ff        <= op_in;
         have_ff      <= have_in;
         neg_ff       <= neg_in;
         err_ff       <= err_in;
         out_valid_ff <= out_valid_in;
      end
      tok_ff <= tok_in;
      out_ff <= out_in;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/infix_expression_evaluator.sv =====
// ----------------------------------------------------------------------------
// Infix expression evaluator
// Evaluates an integer expression with operator precedence, one character
// per request, and returns its value with an error code.
// ----------------------------------------------------------------------------
// Requests enter through a queue port (req_push, req_full) carrying one
// character and a flag marking the last character of an expression. Each
// last character yields exactly one result on rsp_data, read through a queue
// port (rsp_empty, rsp_pop).
// A front end classifies characters in the cycle they are taken and drops
// ignored ones; a token queue feeds the back end. The back end takes a digit
// in its take state and an operator in its take and apply states; an
// operator that applies a multiply or divide occupies the bit-serial unit
// until it is done. The final character passes through a finish state
// that forms the result, which is then held in an output register.
// While a result waits, the back end keeps working until it needs to post
// the next result; requests are refused only when the token queue fills.
// Reset empties the queue, drops any held result and clears the partial sum,
// term, operator and error state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module infix_expression_evaluator #(
   parameter int WORD_BITS   = iee_pkg::WORD_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = iee_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_push,
   input  iee_pkg::req_type   req_data,
   output logic               req_full,
   output logic               rsp_empty,
   input  wire                rsp_pop,
   output iee_pkg::rsp_type   rsp_data
);
   import iee_pkg::*;

   logic                  fifo_push;
   token_type             fifo_wdata;
   logic                  fifo_full;
   logic                  fifo_pop;
   token_type             fifo_rdata;
   logic                  fifo_empty;
   alu_req_type           alu_req;
   alu_rsp_type           alu_rsp;
   logic [WORD_BITS-1:0]  opnd_a;
   logic [WORD_BITS-1:0]  opnd_b;
   logic [WORD_BITS-1:0]  alu_result;

   iee_front u_front (
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .fifo_push (fifo_push),
      .fifo_data (fifo_wdata),
      .fifo_full (fifo_full)
   );

   iee_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fifo_push),
      .push_data (fifo_wdata),
      .full      (fifo_full),
      .pop       (fifo_pop),
      .pop_data  (fifo_rdata),
      .empty     (fifo_empty)
   );

   iee_alu #(
      .WORD_BITS (WORD_BITS)
   ) u_alu (
      .clock   (clock),
      .reset   (reset),
      .alu_req (alu_req),
      .opnd_a  (opnd_a),
      .opnd_b  (opnd_b),
      .alu_rsp (alu_rsp),
      .result  (alu_result)
   );

   iee_back #(
      .WORD_BITS (WORD_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .fifo_empty (fifo_empty),
      .fifo_data  (fifo_rdata),
      .fifo_pop   (fifo_pop),
      .alu_req    (alu_req),
      .opnd_a     (opnd_a),
      .opnd_b     (opnd_b),
      .alu_rsp    (alu_rsp),
      .result     (alu_result),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/iee_checker.sv =====
// ----------------------------------------------------------------------------
// Infix expression evaluator checker
// Port-level assertions on the evaluator, attached to the top level by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iee_checker (
   input wire                clock,
   input wire                reset,
   input wire                req_full,
   input wire                rsp_empty,
   input wire                rsp_pop,
   input iee_pkg::rsp_type   rsp_data
);
   import iee_pkg::*;

   // Reset drops any held result and empties the request queue.
   assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("evaluator not empty after reset");

   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_data.error_code != 2'd3)
      else $error("undefined error code");

   // A failed evaluation reports a zero value.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_data.error_code != ERR_NONE |-> rsp_data.value == '0)
      else $error("nonzero value with error code");

   // A result that is not taken stays in place unchanged.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_data))
      else $error("held result changed");

endmodule

bind infix_expression_evaluator iee_checker u_checker (.*);

`default_nettype wire
